// File: hw/rtl/fsd_pkg.sv
// Package for the Floyd-Steinberg palette dither unit: widths, CSR and function codes,
// channel types and the saturation and error-share helpers.
// No dependencies.
package fsd_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_PALETTE = 256;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int PAL_IDX_W = $clog2(MAX_PALETTE);
   localparam int PS_W      = 9;     // palette_size register
   localparam int RW_W      = 11;    // row_width register
   localparam int RWC_W     = (RW_W > COL_W + 1) ? RW_W : COL_W + 1;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 11;
   localparam int DIFF_W    = 14;    // palette minus channel value
   localparam int SQ_W      = 23;    // one squared difference
   localparam int DIST_W    = 24;    // sum of three squares

   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH    = 1'b1;

   localparam logic FUNC_PALETTE = 1'b0;
   localparam logic FUNC_PIXEL   = 1'b1;

   localparam logic [PS_W-1:0] PS_RESET = 9'd256;
   localparam logic [RW_W-1:0] RW_RESET = 11'd1024;

   // error weights in sixteenths
   localparam logic [3:0] W_RIGHT       = 4'd7;
   localparam logic [3:0] W_BELOW_LEFT  = 4'd3;
   localparam logic [3:0] W_BELOW       = 4'd5;
   localparam logic [3:0] W_BELOW_RIGHT = 4'd1;

   localparam logic signed [15:0] ERR_MAX = 16'sd2047;
   localparam logic signed [15:0] ERR_MIN = -16'sd2048;

   // channel 0 red, 1 green, 2 blue
   typedef logic [2:0][7:0]  rgb_type;
   typedef logic [2:0][11:0] err3_type;

   function automatic logic signed [15:0] sx16(input logic [11:0] v);
      return {{4{v[11]}}, v};
   endfunction

   function automatic logic signed [15:0] zx16(input logic [7:0] v);
      return {8'd0, v};
   endfunction

   function automatic logic [11:0] sat12(input logic signed [15:0] v);
      if (v > ERR_MAX) begin
         return 12'h7FF;
      end else if (v < ERR_MIN) begin
         return 12'h800;
      end
      return v[11:0];
   endfunction

   // (e * k) >>> 4, rounds toward minus infinity
   function automatic logic [11:0] share(input logic [11:0] e, input logic [3:0] k);
      logic signed [15:0] p;
      logic signed [15:0] q;
      p = sx16(e) * $signed({12'd0, k});
      q = p >>> 4;
      return q[11:0];
   endfunction

endpackage

// File: hw/rtl/floyd_steinberg_palette_dither_unit.sv
// Floyd-Steinberg palette dither unit, top level: palette RAM, next-row error RAM,
// distance pipeline and the per-pixel sequencer. Depends on fsd_pkg.
//
//  channel | dir | signals                                         | moves
//  req     | in  | req_valid/ready, func, entry_index, red/grn/blu | palette write or pixel
//  rsp     | out | rsp_valid/ready, color_index                    | one index per pixel
//  csr     | in  | csr_valid/ready, index, data                    | register write
//
// For each pixel the scan reads one palette RAM entry per cycle, over the effective palette
// size, into a 3-stage distance pipeline. After reset a clearing pass zeroes the error RAM;
// req_ready stays low meanwhile, csr is always taken.
// One pixel at a time. A result waiting in rsp does not block the next request; that pixel
// holds in its response step until the result slot frees.
module floyd_steinberg_palette_dither_unit
   import fsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_entry_index,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_color_index,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SUM, ST_SCAN, ST_DRAIN, ST_ERR, ST_WB_LO, ST_WB_HI, ST_RESP
   } state_type;

   state_type            state_ff;
   logic [PS_W-1:0]      palette_size_ff;
   logic [RW_W-1:0]      row_width_ff;
   logic [COL_W-1:0]     clr_ff;
   logic [COL_W-1:0]     column_ff;
   logic [COL_W-1:0]     col_ff;
   logic                 first_ff, last_ff;
   rgb_type              pix_ff;
   err3_type             v_ff, err_ff, fwd_ff, pend_lo_ff, pend_hi_ff;
   logic [PAL_IDX_W-1:0] rd_idx_ff;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_color_index_ff;

   // memories
   rgb_type              pal_mem [MAX_PALETTE];
   err3_type             err_mem [MAX_WIDTH];
   rgb_type              pal_q_ff;
   err3_type             err_q_ff;

   // scan pipeline
   logic                 s1_valid_ff, s1_last_ff;
   logic [PAL_IDX_W-1:0] s1_idx_ff;
   logic                 s2_valid_ff, s2_last_ff;
   logic [PAL_IDX_W-1:0] s2_idx_ff;
   rgb_type              s2_color_ff;
   logic signed [DIFF_W-1:0] s2_diff_ff [3];
   logic                 s3_valid_ff, s3_last_ff;
   logic [PAL_IDX_W-1:0] s3_idx_ff;
   rgb_type              s3_color_ff;
   logic [SQ_W-1:0]      s3_sq_ff [3];
   logic [DIST_W-1:0]    best_d_ff;
   logic [PAL_IDX_W-1:0] best_idx_ff;
   rgb_type              best_color_ff;

   logic                 req_xfer, pal_we, rsp_free;
   logic [PS_W-1:0]      ps_last;
   logic [PAL_IDX_W-1:0] pal_last;
   logic [RWC_W-1:0]     rw_ext, rw_last;
   logic [COL_W-1:0]     col_last, col_eff;
   rgb_type              req_rgb;
   logic                 err_we;
   logic [COL_W-1:0]     err_waddr;
   err3_type             err_wdata;
   err3_type             lo_sum, pend_lo_in, pend_hi_in, fwd_in;
   logic signed [DIFF_W-1:0] s2_diff_in [3];
   logic [SQ_W-1:0]      s3_sq_in [3];
   logic [DIST_W-1:0]    dist_sum;

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_color_index_ff;
   assign req_xfer        = req_valid && req_ready;
   assign rsp_free        = !rsp_valid_ff || rsp_ready;
   assign req_rgb         = {req_blue, req_green, req_red};
   assign pal_we          = req_xfer && (req_func == FUNC_PALETTE)
                            && ({1'b0, req_entry_index} < PS_W'(MAX_PALETTE));

   // effective palette size and row width
   always_comb begin
      if (palette_size_ff == '0) begin
         ps_last = '0;
      end else if (palette_size_ff > PS_W'(MAX_PALETTE)) begin
         ps_last = PS_W'(MAX_PALETTE - 1);
      end else begin
         ps_last = palette_size_ff - 1'b1;
      end
      pal_last = ps_last[PAL_IDX_W-1:0];

      rw_ext = RWC_W'(row_width_ff);
      if (rw_ext < RWC_W'(2)) begin
         rw_last = RWC_W'(1);
      end else if (rw_ext > RWC_W'(MAX_WIDTH)) begin
         rw_last = RWC_W'(MAX_WIDTH - 1);
      end else begin
         rw_last = rw_ext - 1'b1;
      end
      col_last = rw_last[COL_W-1:0];
      col_eff  = (column_ff > col_last) ? col_last : column_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_size_ff <= PS_RESET;
         row_width_ff    <= RW_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PALETTE_SIZE: palette_size_ff <= csr_data[PS_W-1:0];
            CSR_ROW_WIDTH:    row_width_ff    <= csr_data[RW_W-1:0];
            default: ;
         endcase
      end
   end

   // palette RAM
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[req_entry_index[PAL_IDX_W-1:0]] <= req_rgb;
      end
      pal_q_ff <= pal_mem[rd_idx_ff];
   end

   // error shares and writeback data
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         lo_sum[c]     = sat12(sx16(pend_lo_ff[c]) + sx16(share(err_ff[c], W_BELOW_LEFT)));
         pend_lo_in[c] = sat12(sx16(pend_hi_ff[c]) + sx16(share(err_ff[c], W_BELOW)));
         pend_hi_in[c] = share(err_ff[c], W_BELOW_RIGHT);
         fwd_in[c]     = share(err_ff[c], W_RIGHT);
      end
      err_we    = 1'b0;
      err_waddr = col_ff;
      err_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            err_we    = 1'b1;
            err_waddr = clr_ff;
         end
         ST_WB_LO: begin
            err_we    = 1'b1;
            err_waddr = col_ff - 1'b1;
            err_wdata = last_ff ? pend_lo_ff : lo_sum;
         end
         ST_WB_HI: begin
            err_we    = 1'b1;
            err_wdata = pend_hi_ff;
         end
         default: ;
      endcase
   end

   // next-row error RAM; the sequencer keeps reads and writes of one pixel apart
   always_ff @(posedge clock) begin
      if (err_we) begin
         err_mem[err_waddr] <= err_wdata;
      end
      err_q_ff <= err_mem[col_eff];
   end

   // distance pipeline: diff, square, accumulate-compare
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s2_diff_in[c] = $signed({6'd0, pal_q_ff[c]}) - $signed({{2{v_ff[c][11]}}, v_ff[c]});
      end
   end

   always_comb begin
      logic signed [2*DIFF_W-1:0] prod;
      for (int c = 0; c < 3; c++) begin
         prod        = s2_diff_ff[c] * s2_diff_ff[c];
         s3_sq_in[c] = prod[SQ_W-1:0];
      end
   end

   assign dist_sum = DIST_W'(s3_sq_ff[0]) + DIST_W'(s3_sq_ff[1]) + DIST_W'(s3_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= (state_ff == ST_SCAN);
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_last_ff  <= (rd_idx_ff == pal_last);
      s1_idx_ff   <= rd_idx_ff;
      s2_last_ff  <= s1_last_ff;
      s2_idx_ff   <= s1_idx_ff;
      s2_color_ff <= pal_q_ff;
      s3_last_ff  <= s2_last_ff;
      s3_idx_ff   <= s2_idx_ff;
      s3_color_ff <= s2_color_ff;
      for (int c = 0; c < 3; c++) begin
         s2_diff_ff[c] <= s2_diff_in[c];
         s3_sq_ff[c]   <= s3_sq_in[c];
      end
      // entry 0 always loads; strict compare keeps the lowest index on a tie
      if (s3_valid_ff && (s3_idx_ff == '0 || dist_sum < best_d_ff)) begin
         best_d_ff     <= dist_sum;
         best_idx_ff   <= s3_idx_ff;
         best_color_ff <= s3_color_ff;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         column_ff    <= '0;
         rd_idx_ff    <= '0;
         pend_lo_ff   <= '0;
         pend_hi_ff   <= '0;
         fwd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the response step drives rsp_valid itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == COL_W'(MAX_WIDTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_xfer && req_func == FUNC_PIXEL) begin
                  pix_ff   <= req_rgb;
                  col_ff   <= col_eff;
                  first_ff <= (col_eff == '0);
                  last_ff  <= (col_eff == col_last);
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               for (int c = 0; c < 3; c++) begin
                  v_ff[c] <= sat12(zx16(pix_ff[c]) + sx16(err_q_ff[c]) + sx16(fwd_ff[c]));
               end
               rd_idx_ff <= '0;
               state_ff  <= ST_SCAN;
            end
            ST_SCAN: begin
               if (rd_idx_ff == pal_last) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  rd_idx_ff <= rd_idx_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (s3_valid_ff && s3_last_ff) begin
                  state_ff <= ST_ERR;
               end
            end
            ST_ERR: begin
               for (int c = 0; c < 3; c++) begin
                  err_ff[c] <= sat12(sx16(v_ff[c]) - zx16(best_color_ff[c]));
               end
               if (first_ff && !last_ff) begin
                  pend_lo_ff <= '0;
                  pend_hi_ff <= '0;
                  fwd_ff     <= '0;
                  column_ff  <= COL_W'(1);
                  state_ff   <= ST_RESP;
               end else begin
                  state_ff <= ST_WB_LO;
               end
            end
            ST_WB_LO: begin
               if (last_ff) begin
                  state_ff <= ST_WB_HI;
               end else begin
                  pend_lo_ff <= pend_lo_in;
                  pend_hi_ff <= pend_hi_in;
                  fwd_ff     <= fwd_in;
                  column_ff  <= col_ff + 1'b1;
                  state_ff   <= ST_RESP;
               end
            end
            ST_WB_HI: begin
               pend_lo_ff <= '0;
               pend_hi_ff <= '0;
               fwd_ff     <= '0;
               column_ff  <= '0;
               state_ff   <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_color_index_ff <= 8'(best_idx_ff);
                  state_ff           <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   // distance pipeline only carries entries of the current scan
   a_scan_window: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance pipeline active outside scan");

   // writeback to column-1 needs a left neighbor
   a_wb_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB_LO) |-> (col_ff != '0))
      else $error("left writeback at column zero");

   // winner lies inside the searched palette
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR) |-> (best_idx_ff <= pal_last))
      else $error("chosen index beyond palette size");

   // a new result only comes out of the response step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("result transfer raised outside response step");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for floyd_steinberg_palette_dither_unit: a queue-fed driver,
// a response monitor and a bit-accurate error-diffusion predictor.
// Depends on fsd_pkg and the dither unit RTL.
`timescale 1ns / 100ps

module tb_top
   import fsd_pkg::*;
();

   localparam int TOTAL_ITEMS    = 1000;
   localparam int RX_HOLD_CYCLES = 1500;
   localparam int PHASE_SETTLE   = 16;
   localparam int END_SETTLE     = 300;
   localparam int TIMEOUT_NS     = 40_000_000;

   typedef struct packed {
      logic       func;
      logic [7:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } dither_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_func = FUNC_PALETTE;
   logic [7:0]           req_entry_index = 8'd0;
   logic [7:0]           req_red = 8'd0;
   logic [7:0]           req_green = 8'd0;
   logic [7:0]           req_blue = 8'd0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_color_index;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PALETTE_SIZE;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   floyd_steinberg_palette_dither_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_color_index (rsp_color_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ---------------- predictor state ----------------
   logic [7:0]        pal_rgb    [MAX_PALETTE][3];
   logic signed [11:0] row_err   [MAX_WIDTH][3];
   logic signed [11:0] fwd_err   [3];
   logic signed [11:0] pend_left [3];   // next-row sum for column-1
   logic signed [11:0] pend_here [3];   // next-row sum for column
   int                col_pos;
   logic [PS_W-1:0]   cfg_palette_size;
   logic [RW_W-1:0]   cfg_row_width;

   dither_item_type pending_items [$];
   logic [7:0]   expected_index [$];
   int           items_queued = 0;
   int           items_taken = 0;
   int           fail_count = 0;
   bit           tx_quiet = 1'b0;
   bit           rx_quiet = 1'b0;
   int           hold_requests = 0;
   int           holds_served = 0;
   logic         rx_hold = 1'b0;

   function automatic logic signed [11:0] clip12(input int v);
      if (v > 2047) return 12'sh7FF;
      if (v < -2048) return 12'sh800;
      return v[11:0];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] rand8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_channel(input bit extreme);
      if (extreme && $urandom_range(0, 3) != 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return rand8();
   endfunction

   // One accepted item: palette write, or a dithered pixel with its expected index.
   function automatic void dither_step(input dither_item_type it);
      int w, col, n, best, best_d, d, diff, e, i, c;
      int v [3];
      logic [7:0] pix [3];
      pix[0] = it.red;
      pix[1] = it.green;
      pix[2] = it.blue;
      if (it.func == FUNC_PALETTE) begin
         for (c = 0; c < 3; c++) pal_rgb[it.entry_index][c] = pix[c];
         return;
      end
      w = cfg_row_width;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      col = (col_pos > w - 1) ? w - 1 : col_pos;
      for (c = 0; c < 3; c++)
         v[c] = int'(clip12(int'(pix[c]) + int'(row_err[col][c]) + int'(fwd_err[c])));

      n = cfg_palette_size;
      if (n < 1) n = 1;
      if (n > MAX_PALETTE) n = MAX_PALETTE;
      best = 0;
      best_d = 0;
      for (i = 0; i < n; i++) begin
         d = 0;
         for (c = 0; c < 3; c++) begin
            diff = int'(pal_rgb[i][c]) - v[c];
            d += diff * diff;
         end
         if (i == 0 || d < best_d) begin
            best_d = d;
            best = i;
         end
      end

      if (col == w - 1) begin
         for (c = 0; c < 3; c++) begin
            row_err[col-1][c] = pend_left[c];
            row_err[col][c]   = pend_here[c];
            pend_left[c] = '0;
            pend_here[c] = '0;
            fwd_err[c]   = '0;
         end
         col_pos = 0;
      end else if (col == 0) begin
         for (c = 0; c < 3; c++) begin
            pend_left[c] = '0;
            pend_here[c] = '0;
            fwd_err[c]   = '0;
         end
         col_pos = 1;
      end else begin
         for (c = 0; c < 3; c++) begin
            e = int'(clip12(v[c] - int'(pal_rgb[best][c])));
            row_err[col-1][c] = clip12(int'(pend_left[c]) + ((e * 3) >>> 4));
            pend_left[c] = clip12(int'(pend_here[c]) + ((e * 5) >>> 4));
            pend_here[c] = clip12(e >>> 4);
            fwd_err[c]   = clip12((e * 7) >>> 4);
         end
         col_pos = col + 1;
      end
      expected_index.push_back(best[7:0]);
   endfunction

   task automatic queue_entry(input logic [7:0] idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
      pending_items.push_back(dither_item_type'{FUNC_PALETTE, idx, r, g, b});
      items_queued++;
   endtask

   task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      pending_items.push_back(dither_item_type'{FUNC_PIXEL, rand8(), r, g, b});
      items_queued++;
   endtask

   // coarse levels make duplicate entries and equal distances common
   task automatic load_palette(input bit coarse);
      int i;
      for (i = 0; i < MAX_PALETTE; i++) begin
         if (i == 0)
            queue_entry(8'(i), 8'h00, 8'h00, 8'h00);
         else if (i == MAX_PALETTE - 1)
            queue_entry(8'(i), 8'hFF, 8'hFF, 8'hFF);
         else if (coarse)
            queue_entry(8'(i), 8'($urandom_range(0, 3) * 85), 8'($urandom_range(0, 3) * 85),
                        8'($urandom_range(0, 3) * 85));
         else
            queue_entry(8'(i), rand8(), rand8(), rand8());
      end
   endtask

   task automatic wait_idle(input int settle);
      while (items_taken != items_queued || expected_index.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (idx == CSR_PALETTE_SIZE)
         cfg_palette_size = val[PS_W-1:0];
      else
         cfg_row_width = val[RW_W-1:0];
   endtask

   task automatic set_config(input int ps, input int rw);
      write_csr(CSR_PALETTE_SIZE, CSR_DAT_W'(ps));
      write_csr(CSR_ROW_WIDTH, CSR_DAT_W'(rw));
   endtask

   // ---------------- clock, reset, limit ----------------
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout, %0d results still expected", $time, expected_index.size());
      $display("tb_top: FAIL");
      $finish;
   end

   // ---------------- request driver ----------------
   dither_item_type cur_item;
   int           tx_gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            dither_step(cur_item);
            items_taken++;
         end
         if (tx_gap_left > 0) begin
            tx_gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            cur_item = pending_items.pop_front();
            req_func        <= cur_item.func;
            req_entry_index <= cur_item.entry_index;
            req_red         <= cur_item.red;
            req_green       <= cur_item.green;
            req_blue        <= cur_item.blue;
            req_valid       <= 1'b1;
            tx_gap_left = tx_quiet ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- long receiver hold-off ----------------
   int hold_left = 0;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         if (hold_left == 0) rx_hold <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = RX_HOLD_CYCLES;
         rx_hold <= 1'b1;
      end
   end

   // ---------------- response monitor ----------------
   int          rx_stall_left = 0;
   logic [7:0]  want_index;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_index.size() == 0) begin
               $display("%0t: unexpected result, expected none, got color_index %0d",
                        $time, rsp_color_index);
               fail_count++;
            end else begin
               want_index = expected_index.pop_front();
               if (rsp_color_index !== want_index) begin
                  $display("%0t: color_index mismatch, expected %0d, got %0d",
                           $time, want_index, rsp_color_index);
                  fail_count++;
               end
            end
         end
         if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !rx_hold;
            if (!rx_quiet && $urandom_range(0, 99) < 20) rx_stall_left = pick_gap();
         end
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      int i, k, sel, ps, rw, phase_len;
      bit extreme, big;

      for (i = 0; i < MAX_PALETTE; i++)
         for (k = 0; k < 3; k++) pal_rgb[i][k] = 8'd0;
      for (i = 0; i < MAX_WIDTH; i++)
         for (k = 0; k < 3; k++) row_err[i][k] = '0;
      for (k = 0; k < 3; k++) begin
         fwd_err[k]   = '0;
         pend_left[k] = '0;
         pend_here[k] = '0;
      end
      col_pos = 0;
      cfg_palette_size = PS_RESET;
      cfg_row_width    = RW_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset configuration, full palette with ties, primaries and extremes
      load_palette(1'b1);
      queue_pixel(8'h00, 8'h00, 8'h00);
      queue_pixel(8'hFF, 8'hFF, 8'hFF);
      queue_pixel(8'hFF, 8'h00, 8'h00);
      queue_pixel(8'h00, 8'hFF, 8'h00);
      queue_pixel(8'h00, 8'h00, 8'hFF);
      queue_pixel(8'd128, 8'd128, 8'd128);
      queue_pixel(8'd42, 8'd43, 8'd127);
      queue_pixel(8'd1, 8'd254, 8'd170);
      wait_idle(PHASE_SETTLE);

      // size 0 acts as one entry: errors run into saturation both ways
      set_config(0, 6);
      queue_entry(8'd0, 8'h00, 8'h00, 8'h00);
      for (i = 0; i < 48; i++) queue_pixel(8'hFF, 8'hFF, 8'hFF);
      queue_entry(8'd0, 8'hFF, 8'hFF, 8'hFF);
      for (i = 0; i < 48; i++) queue_pixel(8'h00, 8'h00, 8'h00);
      wait_idle(PHASE_SETTLE);
      queue_entry(8'd0, 8'h00, 8'h00, 8'h00);
      wait_idle(PHASE_SETTLE);

      // register extremes, out-of-range values and width cut in mid-row
      set_config(511, 2047);
      for (i = 0; i < 12; i++) queue_pixel(rand8(), rand8(), rand8());
      wait_idle(PHASE_SETTLE);
      write_csr(CSR_ROW_WIDTH, CSR_DAT_W'(1));
      for (i = 0; i < 6; i++) queue_pixel(pick_channel(1), pick_channel(1), pick_channel(1));
      wait_idle(PHASE_SETTLE);
      load_palette(1'b0);
      wait_idle(PHASE_SETTLE);
      set_config(300, 1024);
      for (i = 0; i < 10; i++) queue_pixel(rand8(), rand8(), rand8());
      wait_idle(PHASE_SETTLE);
      set_config(1, 2);
      for (i = 0; i < 6; i++) queue_pixel(pick_channel(1), pick_channel(1), pick_channel(1));
      wait_idle(PHASE_SETTLE);

      // receiver holds off while the sender keeps offering pixels
      set_config(3, 7);
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      hold_requests++;
      for (i = 0; i < 40; i++) queue_pixel(rand8(), rand8(), rand8());
      wait_idle(PHASE_SETTLE);

      while (items_queued < TOTAL_ITEMS) begin
         if ($urandom_range(0, 9) == 0) load_palette($urandom_range(0, 1));
         sel = $urandom_range(0, 99);
         big = 1'b0;
         if (sel < 65) begin
            ps = $urandom_range(1, 16);
         end else if (sel < 88) begin
            ps = $urandom_range(17, 96);
         end else begin
            case ($urandom_range(0, 3))
               0: ps = 256;
               1: ps = 511;
               2: ps = $urandom_range(257, 510);
               default: ps = 0;
            endcase
            big = (ps != 0);
         end
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            rw = $urandom_range(2, 10);
         end else if (sel < 85) begin
            rw = $urandom_range(11, 64);
         end else begin
            case ($urandom_range(0, 5))
               0: rw = 0;
               1: rw = 1;
               2: rw = 1024;
               3: rw = 2047;
               4: rw = $urandom_range(1025, 2046);
               default: rw = $urandom_range(65, 1023);
            endcase
         end
         wait_idle(PHASE_SETTLE);
         set_config(ps, rw);
         tx_quiet = ($urandom_range(0, 4) == 0);
         rx_quiet = ($urandom_range(0, 4) == 0);
         extreme  = ($urandom_range(0, 3) == 0);
         phase_len = big ? $urandom_range(8, 20) : $urandom_range(30, 100);
         for (i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 99) < 12)
               queue_entry(rand8(), rand8(), rand8(), rand8());
            else
               queue_pixel(pick_channel(extreme), pick_channel(extreme), pick_channel(extreme));
         end
         wait_idle(PHASE_SETTLE);
      end

      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      wait_idle(END_SETTLE);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
